/* hdl/pcnl_pkg.sv */
// Shared types, constants and helper functions for the periodic cell neighbour list.
package pcnl_pkg;

  // Field and register widths
  localparam int DIM_W    = 7;   // cells per axis, also coordinate width
  localparam int IDX_W    = 18;  // linear cell index
  localparam int NB_W     = 19;  // neighbour index, two's complement
  localparam int SLOT_W   = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int PLANE_W  = 2 * DIM_W - 1;    // nx*ny up to 64*64
  localparam int TOTAL_W  = PLANE_W + DIM_W;  // nx*ny*nz
  localparam int SUM_W    = TOTAL_W + 1;      // recomposed index with headroom

  // Grid limits
  localparam logic [DIM_W-1:0] MAX_CELLS_PER_AXIS = 7'd64;
  localparam int               NEIGHBORHOOD       = 27;
  localparam logic [SLOT_W-1:0] SLOT_LAST         = SLOT_W'(NEIGHBORHOOD - 1);
  localparam logic [NB_W-1:0]  NONE_CODE          = {NB_W{1'b1}};
  localparam logic [SUM_W-1:0] INDEX_LIMIT        = SUM_W'(262143);

  // Divider: bits retired per cycle and cycles per pass
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = IDX_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Item queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register map (word index)
  localparam logic [2:0] REG_CELLS_X = 3'd0;
  localparam logic [2:0] REG_CELLS_Y = 3'd1;
  localparam logic [2:0] REG_CELLS_Z = 3'd2;
  localparam logic [2:0] REG_WRAP_X  = 3'd3;
  localparam logic [2:0] REG_WRAP_Y  = 3'd4;
  localparam logic [2:0] REG_WRAP_Z  = 3'd5;

  // Offset codes along one axis: counter value minus one
  localparam logic [1:0] OFS_NEG  = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS  = 2'd2;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DIV_X,
    FR_DIV_Y,
    FR_DIV_Z,
    FR_PUSH
  } pcnl_front_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] nx;
    logic [DIM_W-1:0] ny;
    logic [DIM_W-1:0] nz;
    logic             wx;
    logic             wy;
    logic             wz;
  } pcnl_cfg_t;

  // One classified item as handed from front to back
  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] centre;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [DIM_W-1:0] cz;
  } pcnl_item_t;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] p;
  } pcnl_axis_t;

  // Apply one offset on one axis; ok clear when it leaves an unwrapped grid
  function automatic pcnl_axis_t shift_axis(input logic [DIM_W-1:0] c,
                                            input logic [1:0]       d,
                                            input logic [DIM_W-1:0] n,
                                            input logic             wrap);
    logic [DIM_W:0] v;
    logic           lo;
    logic           hi;
    pcnl_axis_t     r;
    lo = (d == OFS_NEG) && (c == '0);
    unique case (d)
      OFS_NEG:  v = {1'b0, c} - (DIM_W+1)'(1);
      OFS_POS:  v = {1'b0, c} + (DIM_W+1)'(1);
      default:  v = {1'b0, c};
    endcase
    hi   = !lo && (v >= {1'b0, n});
    r.ok = wrap || (!lo && !hi);
    if (lo) begin
      r.p = n - DIM_W'(1);
    end else if (hi) begin
      r.p = DIM_W'(v - {1'b0, n});
    end else begin
      r.p = v[DIM_W-1:0];
    end
    return r;
  endfunction

  // Clamp a written cell count to the axis limit
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : v;
  endfunction

endpackage

/* hdl/pcnl_div.sv */
// Iterative restoring divider, three quotient bits per cycle.
module pcnl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcnl_pkg::IDX_W-1:0]    dividend,
  input  logic [pcnl_pkg::DIM_W-1:0]    divisor,
  output logic                          done,
  output logic [pcnl_pkg::IDX_W-1:0]    quotient,
  output logic [pcnl_pkg::DIM_W-1:0]    remainder
);

  logic [pcnl_pkg::IDX_W-1:0]  quo_r, quo_nxt;
  logic [pcnl_pkg::DIM_W-1:0]  rem_r, rem_nxt;
  logic [pcnl_pkg::DIM_W-1:0]  dvs_r;
  logic [pcnl_pkg::STEP_W-1:0] cnt_r;
  logic                        run_r;
  logic                        done_r;

  // Three dependent shift-subtract steps on the partial remainder
  always_comb begin
    logic [pcnl_pkg::DIM_W:0]   t;
    logic [pcnl_pkg::DIM_W-1:0] r;
    logic [pcnl_pkg::IDX_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < pcnl_pkg::DIV_BITS; k++) begin
      t = {r, q[pcnl_pkg::IDX_W-1]};
      q = {q[pcnl_pkg::IDX_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t    = t - {1'b0, dvs_r};
        q[0] = 1'b1;
      end
      r = t[pcnl_pkg::DIM_W-1:0];
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= pcnl_pkg::STEP_W'(pcnl_pkg::DIV_STEPS - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - pcnl_pkg::STEP_W'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hdl/pcnl_front.sv */
// Front end: accepts a cell index and splits it into x, y and z coordinates.
module pcnl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcnl_pkg::pcnl_cfg_t           cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcnl_pkg::IDX_W-1:0]    in_cell_index,
  input  logic                          q_full,
  output logic                          q_push,
  output pcnl_pkg::pcnl_item_t          q_item
);

  pcnl_pkg::pcnl_front_state_t state_r, state_nxt;

  logic                         active_r;
  logic [pcnl_pkg::IDX_W-1:0]   cell_r;
  logic [pcnl_pkg::DIM_W-1:0]   cx_r, cy_r, czs_r, czm_r;

  logic                         accept;
  logic                         active_now;
  logic                         div_start;
  logic [pcnl_pkg::IDX_W-1:0]   div_dividend;
  logic [pcnl_pkg::DIM_W-1:0]   div_divisor;
  logic                         div_done;
  logic [pcnl_pkg::IDX_W-1:0]   div_quotient;
  logic [pcnl_pkg::DIM_W-1:0]   div_remainder;

  assign active_now = (cfg.nx != '0) && (cfg.ny != '0) && (cfg.nz != '0);

  pcnl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcnl_pkg::FR_IDLE: begin
        if (start) begin
          state_nxt = active_now ? pcnl_pkg::FR_DIV_X : pcnl_pkg::FR_PUSH;
        end
      end
      pcnl_pkg::FR_DIV_X: begin
        if (div_done) state_nxt = pcnl_pkg::FR_DIV_Y;
      end
      pcnl_pkg::FR_DIV_Y: begin
        if (div_done) state_nxt = pcnl_pkg::FR_DIV_Z;
      end
      pcnl_pkg::FR_DIV_Z: begin
        if (div_done) state_nxt = pcnl_pkg::FR_PUSH;
      end
      pcnl_pkg::FR_PUSH: begin
        if (!q_full) begin
          if (start) begin
            state_nxt = active_now ? pcnl_pkg::FR_DIV_X : pcnl_pkg::FR_PUSH;
          end else begin
            state_nxt = pcnl_pkg::FR_IDLE;
          end
        end
      end
      default: state_nxt = pcnl_pkg::FR_IDLE;
    endcase
  end

  // Outputs: handshake, queue push and divider operands
  always_comb begin
    busy         = 1'b1;
    q_push       = 1'b0;
    div_dividend = in_cell_index;
    div_divisor  = cfg.nx;
    unique case (state_r)
      pcnl_pkg::FR_IDLE: begin
        busy = 1'b0;
      end
      pcnl_pkg::FR_DIV_X: begin
        div_dividend = div_quotient;
        div_divisor  = cfg.ny;
      end
      pcnl_pkg::FR_DIV_Y: begin
        div_dividend = div_quotient;
        div_divisor  = cfg.nz;
      end
      pcnl_pkg::FR_PUSH: begin
        busy   = q_full;
        q_push = !q_full;
      end
      default: busy = 1'b1;
    endcase
    accept    = start && !busy;
    div_start = (accept && active_now) ||
                (div_done && (state_r == pcnl_pkg::FR_DIV_X ||
                              state_r == pcnl_pkg::FR_DIV_Y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcnl_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Coordinate registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r   <= in_cell_index;
      active_r <= active_now;
      cx_r     <= '0;
      cy_r     <= '0;
      czs_r    <= '0;
      czm_r    <= '0;
    end else if (div_done) begin
      unique case (state_r)
        pcnl_pkg::FR_DIV_X: cx_r <= div_remainder;
        pcnl_pkg::FR_DIV_Y: begin
          cy_r  <= div_remainder;
          // z beyond any legal size saturates, comparisons stay exact
          czs_r <= (|div_quotient[pcnl_pkg::IDX_W-1:pcnl_pkg::DIM_W]) ?
                   {pcnl_pkg::DIM_W{1'b1}} : div_quotient[pcnl_pkg::DIM_W-1:0];
        end
        pcnl_pkg::FR_DIV_Z: czm_r <= div_remainder;
        default: ;
      endcase
    end
  end

  // Item for the back end: wrapped z uses the reduced coordinate
  always_comb begin
    q_item.active = active_r;
    q_item.centre = cell_r;
    q_item.cx     = cx_r;
    q_item.cy     = cy_r;
    q_item.cz     = cfg.wz ? czm_r : czs_r;
  end

endmodule

/* hdl/pcnl_queue.sv */
// Short item queue between front and back ends.
module pcnl_queue #(
  parameter int DEPTH = pcnl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pcnl_pkg::pcnl_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output pcnl_pkg::pcnl_item_t  head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  pcnl_pkg::pcnl_item_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

/* hdl/pcnl_back.sv */
// Back end: walks the 27 offsets of an item and recomposes neighbour indices.
module pcnl_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcnl_pkg::pcnl_cfg_t             cfg,
  input  logic                            q_valid,
  input  pcnl_pkg::pcnl_item_t            q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  output logic [pcnl_pkg::SLOT_W-1:0]     out_slot,
  output logic signed [pcnl_pkg::NB_W-1:0] out_neighbor_index,
  output logic                            out_index_error,
  output logic                            out_last
);

  // Offset walker
  logic [1:0]                  dx_r, dy_r, dz_r;
  logic [pcnl_pkg::SLOT_W-1:0] slot_r;
  logic                        slot_last;

  // Grid sizes, recomputed from the registers
  logic [pcnl_pkg::PLANE_W-1:0] plane_r;
  logic [pcnl_pkg::TOTAL_W-1:0] total_r;

  // Stage 1: per-axis neighbour coordinates
  logic                         s1_v_r, s1_last_r, s1_ok_r;
  logic [pcnl_pkg::SLOT_W-1:0]  s1_slot_r;
  logic [pcnl_pkg::IDX_W-1:0]   s1_cell_r;
  logic [pcnl_pkg::DIM_W-1:0]   s1_px_r, s1_py_r, s1_pz_r;

  // Stage 2: partial products
  logic                         s2_v_r, s2_last_r, s2_ok_r;
  logic [pcnl_pkg::SLOT_W-1:0]  s2_slot_r;
  logic [pcnl_pkg::IDX_W-1:0]   s2_cell_r;
  logic [pcnl_pkg::TOTAL_W-1:0] s2_pzp_r;
  logic [pcnl_pkg::DIM_W*2-1:0] s2_pyn_r;
  logic [pcnl_pkg::DIM_W-1:0]   s2_px_r;

  // Output stage
  logic                          out_valid_r, out_last_r, out_err_r;
  logic [pcnl_pkg::SLOT_W-1:0]   out_slot_r;
  logic [pcnl_pkg::NB_W-1:0]     out_nb_r;

  pcnl_pkg::pcnl_axis_t ax, ay, az;
  logic [pcnl_pkg::SUM_W-1:0] idx;
  logic                       err_nxt;
  logic [pcnl_pkg::NB_W-1:0]  nb_nxt;

  assign slot_last = (slot_r == pcnl_pkg::SLOT_LAST);
  assign q_pop     = q_valid && slot_last;

  always_ff @(posedge clk) begin
    plane_r <= pcnl_pkg::PLANE_W'(cfg.nx) * pcnl_pkg::PLANE_W'(cfg.ny);
    total_r <= pcnl_pkg::TOTAL_W'(plane_r) * pcnl_pkg::TOTAL_W'(cfg.nz);
  end

  // Offset counters: x fastest, then y, then z
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r   <= pcnl_pkg::OFS_NEG;
      dy_r   <= pcnl_pkg::OFS_NEG;
      dz_r   <= pcnl_pkg::OFS_NEG;
      slot_r <= '0;
    end else if (q_valid) begin
      if (slot_last) begin
        dx_r   <= pcnl_pkg::OFS_NEG;
        dy_r   <= pcnl_pkg::OFS_NEG;
        dz_r   <= pcnl_pkg::OFS_NEG;
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + pcnl_pkg::SLOT_W'(1);
        if (dx_r != pcnl_pkg::OFS_POS) begin
          dx_r <= dx_r + 2'd1;
        end else begin
          dx_r <= pcnl_pkg::OFS_NEG;
          if (dy_r != pcnl_pkg::OFS_POS) begin
            dy_r <= dy_r + 2'd1;
          end else begin
            dy_r <= pcnl_pkg::OFS_NEG;
            dz_r <= dz_r + 2'd1;
          end
        end
      end
    end
  end

  assign ax = pcnl_pkg::shift_axis(q_item.cx, dx_r, cfg.nx, cfg.wx);
  assign ay = pcnl_pkg::shift_axis(q_item.cy, dy_r, cfg.ny, cfg.wy);
  assign az = pcnl_pkg::shift_axis(q_item.cz, dz_r, cfg.nz, cfg.wz);

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= q_valid;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  // Stage 1 and stage 2 payload
  always_ff @(posedge clk) begin
    s1_slot_r <= slot_r;
    s1_last_r <= slot_last;
    s1_ok_r   <= q_item.active && ax.ok && ay.ok && az.ok;
    s1_cell_r <= q_item.centre;
    s1_px_r   <= ax.p;
    s1_py_r   <= ay.p;
    s1_pz_r   <= az.p;

    s2_slot_r <= s1_slot_r;
    s2_last_r <= s1_last_r;
    s2_ok_r   <= s1_ok_r;
    s2_cell_r <= s1_cell_r;
    s2_pzp_r  <= pcnl_pkg::TOTAL_W'(s1_pz_r) * pcnl_pkg::TOTAL_W'(plane_r);
    s2_pyn_r  <= (pcnl_pkg::DIM_W*2)'(s1_py_r) * (pcnl_pkg::DIM_W*2)'(cfg.nx);
    s2_px_r   <= s1_px_r;
  end

  // Sum, range check and self check
  always_comb begin
    idx     = pcnl_pkg::SUM_W'(s2_pzp_r) + pcnl_pkg::SUM_W'(s2_pyn_r) +
              pcnl_pkg::SUM_W'(s2_px_r);
    err_nxt = s2_ok_r && ((idx >= pcnl_pkg::SUM_W'(total_r)) ||
                          (idx > pcnl_pkg::INDEX_LIMIT));
    if (s2_ok_r && !err_nxt && (idx != pcnl_pkg::SUM_W'(s2_cell_r))) begin
      nb_nxt = idx[pcnl_pkg::NB_W-1:0];
    end else begin
      nb_nxt = pcnl_pkg::NONE_CODE;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r <= s2_slot_r;
    out_last_r <= s2_last_r;
    out_err_r  <= err_nxt;
    out_nb_r   <= nb_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_neighbor_index = out_nb_r;
  assign out_index_error    = out_err_r;
  assign out_last           = out_last_r;

endmodule

/* hdl/periodic_cell_neighbor_list.sv */
// Top level of the periodic 27-neighbour cell list with its register port.
//
// Each accepted cell index yields 27 results on consecutive cycles, slot 0 to
// 26 with x fastest, each shown for one cycle under out_valid; the receiver
// cannot stall, so results must be taken as they appear. The sustained rate is
// set by the back end, which emits one neighbour per cycle while the queue holds an item.
// The front end splits the index with a shared divider retiring three bits a
// cycle over three passes (x, y, then z), so it runs ahead of the back end and
// busy only stays high while it divides or the item queue is full. The first
// result of an item comes through the three divider passes, the item queue,
// back-end stages 1 and 2 and the output register. Write the grid registers only
// while the block is idle.
module periodic_cell_neighbor_list #(
  parameter int QUEUE_DEPTH = pcnl_pkg::QUEUE_DEPTH_DEF  // 1 to 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [pcnl_pkg::IDX_W-1:0]       in_cell_index,
  // Results
  output logic                             out_valid,
  output logic [pcnl_pkg::SLOT_W-1:0]      out_slot,
  output logic signed [pcnl_pkg::NB_W-1:0] out_neighbor_index,
  output logic                             out_index_error,
  output logic                             out_last,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcnl_pkg::ADDR_W-1:0]      paddr,
  input  logic [pcnl_pkg::DATA_W-1:0]      pwdata,
  output logic [pcnl_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  pcnl_pkg::pcnl_cfg_t  cfg_r;
  pcnl_pkg::pcnl_item_t push_item, head_item;
  logic                 cfg_wr;
  logic [2:0]           cfg_sel;
  logic                 q_full, q_push, q_pop, q_valid;

  // Register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nx <= pcnl_pkg::DIM_W'(1);
      cfg_r.ny <= pcnl_pkg::DIM_W'(1);
      cfg_r.nz <= pcnl_pkg::DIM_W'(1);
      cfg_r.wx <= 1'b0;
      cfg_r.wy <= 1'b0;
      cfg_r.wz <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        pcnl_pkg::REG_CELLS_X: cfg_r.nx <= pcnl_pkg::sat_dim(pwdata[pcnl_pkg::DIM_W-1:0]);
        pcnl_pkg::REG_CELLS_Y: cfg_r.ny <= pcnl_pkg::sat_dim(pwdata[pcnl_pkg::DIM_W-1:0]);
        pcnl_pkg::REG_CELLS_Z: cfg_r.nz <= pcnl_pkg::sat_dim(pwdata[pcnl_pkg::DIM_W-1:0]);
        pcnl_pkg::REG_WRAP_X:  cfg_r.wx <= pwdata[0];
        pcnl_pkg::REG_WRAP_Y:  cfg_r.wy <= pwdata[0];
        pcnl_pkg::REG_WRAP_Z:  cfg_r.wz <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      pcnl_pkg::REG_CELLS_X: prdata = pcnl_pkg::DATA_W'(cfg_r.nx);
      pcnl_pkg::REG_CELLS_Y: prdata = pcnl_pkg::DATA_W'(cfg_r.ny);
      pcnl_pkg::REG_CELLS_Z: prdata = pcnl_pkg::DATA_W'(cfg_r.nz);
      pcnl_pkg::REG_WRAP_X:  prdata = pcnl_pkg::DATA_W'(cfg_r.wx);
      pcnl_pkg::REG_WRAP_Y:  prdata = pcnl_pkg::DATA_W'(cfg_r.wy);
      pcnl_pkg::REG_WRAP_Z:  prdata = pcnl_pkg::DATA_W'(cfg_r.wz);
      default:               prdata = '0;
    endcase
  end

  pcnl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .start         (start),
    .busy          (busy),
    .in_cell_index (in_cell_index),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  pcnl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  pcnl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_item             (head_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_slot           (out_slot),
    .out_neighbor_index (out_neighbor_index),
    .out_index_error    (out_index_error),
    .out_last           (out_last)
  );

endmodule
